@@ rtl/message_header_deframer_defines.svh @@
// Assertion macros for the message header deframer
`ifndef MESSAGE_HEADER_DEFRAMER_DEFINES_SVH
`define MESSAGE_HEADER_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF

`define MHD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mhd assertion failed");

`define MHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mhd assertion failed");

`else

`define MHD_ASSERT_SAME(label, clk, rst, ante, cons)

`define MHD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/mhd_pkg.sv @@
// Shared types and codes for the message header deframer
`timescale 1ns / 1ps
`default_nettype none

package mhd_pkg;

   // parser phases
   localparam logic [2:0] PH_ID      = 3'd0;
   localparam logic [2:0] PH_STAMP   = 3'd1;
   localparam logic [2:0] PH_LENGTH  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CLIENT  = 3'd4;
   localparam logic [2:0] PH_HALTED  = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_EMPTY     = 2'd1;
   localparam logic [1:0] KIND_SUBSCRIBE = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // message ids
   localparam logic [31:0] CAN_ID_LOW = 32'd10;
   localparam logic [31:0] CAN_ID_END = 32'd2048;
   localparam logic [31:0] ID_CLIENT  = 32'd0;
   localparam logic [31:0] ID_LEN_A   = 32'd2;
   localparam logic [31:0] ID_LEN_B   = 32'd4;
   localparam logic [31:0] ID_FIX_16  = 32'd5;
   localparam logic [31:0] ID_FIX_18  = 32'd6;
   localparam logic [31:0] ID_FIX_20  = 32'd7;

   localparam logic [31:0] LEN_FIX_16 = 32'd16;
   localparam logic [31:0] LEN_FIX_18 = 32'd18;
   localparam logic [31:0] LEN_FIX_20 = 32'd20;
   localparam logic [31:0] CAN_BYTES  = 32'd8;

   localparam logic [2:0] FIELD_LAST  = 3'd3;   // last byte of a 4-byte field
   localparam logic [2:0] STAMP_LAST  = 3'd7;   // last of 8 timestamp bytes

   localparam logic [7:0] ROLE_LOW    = 8'd1;
   localparam logic [7:0] ROLE_HIGH   = 8'd3;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  field_count;
      logic [31:0] id_value;
      logic [31:0] length_value;
      logic [31:0] payload_count;
      logic [7:0]  role_value;
   } parse_state_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [10:0] message_id;
      logic [7:0]  payload_byte;
      logic [31:0] byte_index;
      logic        last;
      logic [1:0]  client_role;
      logic [31:0] bad_value;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/mhd_step.sv @@
// Per-byte parse step: next parser state and the result the byte causes
`timescale 1ns / 1ps
`default_nettype none

module mhd_step
   import mhd_pkg::*;
(
   input  wire  parse_state_type state_cur,
   input  wire  logic [7:0]      data_byte,
   output parse_state_type       state_nxt,
   output rsp_item_type          result
);

   logic [31:0] field_acc;
   logic [31:0] count_inc;
   logic        is_can;

   // little-endian field assembly, one byte lane per header byte
   assign field_acc = ((state_cur.phase == PH_LENGTH) ? state_cur.length_value
                                                      : state_cur.id_value)
                      | ({24'd0, data_byte} << {state_cur.field_count[1:0], 3'b000});
   assign count_inc = state_cur.payload_count + 32'd1;
   assign is_can    = (field_acc >= CAN_ID_LOW) && (field_acc < CAN_ID_END);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;

      unique case (state_cur.phase)
         PH_ID: begin
            state_nxt.id_value    = field_acc;
            state_nxt.field_count = state_cur.field_count + 3'd1;
            if (state_cur.field_count == FIELD_LAST) begin
               state_nxt.field_count   = 3'd0;
               state_nxt.payload_count = 32'd0;
               if (is_can) begin
                  state_nxt.phase = PH_STAMP;
               end else if (field_acc == ID_FIX_16) begin
                  state_nxt.phase        = PH_PAYLOAD;
                  state_nxt.length_value = LEN_FIX_16;
               end else if (field_acc == ID_FIX_18) begin
                  state_nxt.phase        = PH_PAYLOAD;
                  state_nxt.length_value = LEN_FIX_18;
               end else if (field_acc == ID_FIX_20) begin
                  state_nxt.phase        = PH_PAYLOAD;
                  state_nxt.length_value = LEN_FIX_20;
               end else if (field_acc == ID_CLIENT) begin
                  state_nxt.payload_count = state_cur.payload_count;
                  state_nxt.phase         = PH_CLIENT;
               end else if (field_acc == ID_LEN_A || field_acc == ID_LEN_B) begin
                  state_nxt.payload_count = state_cur.payload_count;
                  state_nxt.length_value  = 32'd0;
                  state_nxt.phase         = PH_LENGTH;
               end else begin
                  state_nxt.payload_count = state_cur.payload_count;
                  state_nxt.phase         = PH_HALTED;
                  result.valid            = 1'b1;
                  result.kind             = KIND_ERROR;
                  result.bad_value        = field_acc;
               end
            end
         end
         PH_STAMP: begin
            if (state_cur.field_count == STAMP_LAST) begin
               state_nxt.field_count   = 3'd0;
               state_nxt.length_value  = CAN_BYTES;
               state_nxt.payload_count = 32'd0;
               state_nxt.phase         = PH_PAYLOAD;
            end else begin
               state_nxt.field_count = state_cur.field_count + 3'd1;
            end
         end
         PH_LENGTH: begin
            state_nxt.length_value = field_acc;
            state_nxt.field_count  = state_cur.field_count + 3'd1;
            if (state_cur.field_count == FIELD_LAST) begin
               state_nxt.field_count = 3'd0;
               if (field_acc == 32'd0) begin
                  state_nxt.phase    = PH_ID;
                  state_nxt.id_value = 32'd0;
                  result.valid       = 1'b1;
                  result.kind        = KIND_EMPTY;
                  result.message_id  = state_cur.id_value[10:0];
               end else begin
                  state_nxt.payload_count = 32'd0;
                  state_nxt.phase         = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.message_id   = state_cur.id_value[10:0];
            result.payload_byte = data_byte;
            result.byte_index   = state_cur.payload_count;
            // count stays below length, so +1 cannot wrap here
            if (count_inc == state_cur.length_value) begin
               result.last             = 1'b1;
               state_nxt.phase         = PH_ID;
               state_nxt.id_value      = 32'd0;
               state_nxt.payload_count = 32'd0;
            end else begin
               state_nxt.payload_count = count_inc;
            end
         end
         PH_CLIENT: begin
            if (state_cur.field_count == 3'd0) begin
               state_nxt.role_value  = data_byte;
               state_nxt.field_count = 3'd1;
            end else begin
               state_nxt.field_count = 3'd0;
               state_nxt.phase       = PH_ID;
               state_nxt.id_value    = 32'd0;
               if (data_byte != 8'd0) begin
                  result.valid = 1'b1;
                  if (state_cur.role_value >= ROLE_LOW && state_cur.role_value <= ROLE_HIGH) begin
                     result.kind        = KIND_SUBSCRIBE;
                     result.client_role = 2'(state_cur.role_value - ROLE_LOW);
                  end else begin
                     result.kind      = KIND_ERROR;
                     result.bad_value = {24'd0, state_cur.role_value};
                     state_nxt.phase  = PH_HALTED;
                  end
               end
            end
         end
         default: begin
            // halted, or a code with no meaning: ignore the byte
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/message_header_deframer.sv @@
// Top level of the message header deframer: handshakes, parser state and result register
`timescale 1ns / 1ps
`default_nettype none

// Parses a byte stream into messages at one byte per clock. Each accepted
// item (one byte) updates the parser state in the cycle it is taken, and any
// result it causes appears on the rsp_ port from the next cycle on, held in a
// single output register. req_ready drops only while that register holds a
// result the consumer has not taken; with rsp_ready high the block sustains
// one item per cycle. After a protocol error the block still takes bytes but
// gives no further results until reset.
`include "message_header_deframer_defines.svh"

module message_header_deframer
   import mhd_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [7:0]  req_data_byte,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [10:0]       rsp_message_id,
   output logic [7:0]        rsp_payload_byte,
   output logic [31:0]       rsp_byte_index,
   output logic              rsp_last,
   output logic [1:0]        rsp_client_role,
   output logic [31:0]       rsp_bad_value
);

   parse_state_type state_ff;
   parse_state_type state_in;
   rsp_item_type    step_result;
   rsp_item_type    rsp_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            accept;
   logic            load;

   mhd_step u_step (
      .state_cur (state_ff),
      .data_byte (req_data_byte),
      .state_nxt (state_in),
      .result    (step_result)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign load      = accept && step_result.valid;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_message_id   = rsp_ff.message_id;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_last         = rsp_ff.last;
   assign rsp_client_role  = rsp_ff.client_role;
   assign rsp_bad_value    = rsp_ff.bad_value;

   // halt is sticky until reset
   `MHD_ASSERT_NEXT(a_halt_sticky, clock, reset, state_ff.phase == PH_HALTED, state_ff.phase == PH_HALTED)

   // an error result on the port means the parser has halted
   `MHD_ASSERT_SAME(a_error_halts, clock, reset, rsp_valid_ff && rsp_ff.kind == KIND_ERROR, state_ff.phase == PH_HALTED)

   // the final payload byte returns the parser to id collection with a clean id
   `MHD_ASSERT_NEXT(a_last_restarts, clock, reset, load && step_result.last, state_ff.phase == PH_ID && state_ff.id_value == 32'd0)

   // a 4-byte header field never counts past its last byte
   `MHD_ASSERT_SAME(a_field_range, clock, reset, state_ff.phase == PH_ID || state_ff.phase == PH_LENGTH, state_ff.field_count <= FIELD_LAST)

endmodule

`default_nettype wire
